// File: hw/rtl/pn9crc_pkg.sv
// shared types, constants and bit functions of the pn9 dewhitening frame receiver
package pn9crc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_CRCH,
        PH_CRCL
    } t_phase;

    typedef enum logic [2:0] {
        K_LEN,
        K_BODY,
        K_CRCH,
        K_CRCL,
        K_LONG
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] dw;
        logic [7:0] idx;
        logic [7:0] len;
        logic [7:0] plen;
    } t_item;

    localparam logic [7:0]  PN9_SEED      = 8'hFF;
    localparam logic        PN9_CARRY     = 1'b1;
    localparam logic [15:0] CRC16_GEN     = 16'h8005;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [7:0]  BYTE1_MASK    = 8'h89;
    localparam logic [7:0]  CHAIN_ADD     = 8'hDC;
    localparam logic [7:0]  MAX_LEN_RESET = 8'd64;
    localparam logic [8:0]  LEN_OVERHEAD  = 9'd3;

    localparam logic [1:0] ST_BUSY     = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_CRC_ERR  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // eight lfsr steps, {carry, key}
    function automatic logic [8:0] pn9_step(input logic [8:0] st);
        logic [7:0] k;
        logic       c;
        logic       nc;
        k = st[7:0];
        c = st[8];
        for (int b = 0; b < 8; b++) begin
            nc = k[5] ^ k[0];
            k  = {c, k[7:1]};
            c  = nc;
        end
        return {c, k};
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] v);
        logic [15:0] c;
        logic [7:0]  x;
        logic        top;
        c = crc;
        x = v;
        for (int b = 0; b < 8; b++) begin
            top = c[15] ^ x[7];
            c   = {c[14:0], 1'b0};
            if (top) begin
                c = c ^ CRC16_GEN;
            end
            x = {x[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/pn9crc_in_if.sv
// input byte channel
interface pn9crc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       frame_start;

    modport source(output valid, raw_byte, frame_start, input ready);
    modport sink(input valid, raw_byte, frame_start, output ready);
endinterface

// File: hw/rtl/pn9crc_out_if.sv
// result channel
interface pn9crc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       is_payload;
    logic       end_of_frame;
    logic [1:0] frame_status;
    logic [7:0] payload_length;

    modport source(output valid, data_byte, byte_index, is_payload, end_of_frame,
                   frame_status, payload_length, input ready);
    modport sink(input valid, data_byte, byte_index, is_payload, end_of_frame,
                 frame_status, payload_length, output ready);
endinterface

// File: hw/rtl/pn9crc_cfg_if.sv
// configuration write channel
interface pn9crc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_frame_length;

    modport source(output valid, max_frame_length, input ready);
    modport sink(input valid, max_frame_length, output ready);
endinterface

// File: hw/rtl/pn9crc_front.sv
// front end: dewhitening, frame tracking and classification of each byte
module pn9crc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pn9crc_in_if.sink          i_byte,
    pn9crc_cfg_if.sink         i_cfg,
    input  logic               i_full,
    output logic               o_push,
    output pn9crc_pkg::t_item  o_item
);
    import pn9crc_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_key, n_key;
    logic       r_carry, n_carry;
    logic [7:0] r_count;
    logic [7:0] r_len;
    logic [7:0] r_max_len;

    logic       w_acc;
    logic       w_active;
    t_phase     w_phase;
    logic [7:0] w_key;
    logic       w_carry;
    logic [7:0] w_idx;
    logic [7:0] w_dw;
    logic       w_too_long;
    logic [8:0] w_pn9;

    assign i_byte.ready = !i_full;
    assign i_cfg.ready  = 1'b1;

    assign w_acc      = i_byte.valid && i_byte.ready;
    assign w_active   = i_byte.frame_start || (r_phase != PH_IDLE);
    assign w_phase    = i_byte.frame_start ? PH_BODY : r_phase;
    assign w_key      = i_byte.frame_start ? PN9_SEED : r_key;
    assign w_carry    = i_byte.frame_start ? PN9_CARRY : r_carry;
    assign w_idx      = i_byte.frame_start ? 8'd0 : r_count;
    assign w_dw       = i_byte.raw_byte ^ w_key;
    assign w_too_long = ({1'b0, w_dw} + LEN_OVERHEAD) >= {1'b0, r_max_len};
    assign w_pn9      = pn9_step({w_carry, w_key});
    assign n_key      = w_pn9[7:0];
    assign n_carry    = w_pn9[8];

    always_comb begin
        n_phase = r_phase;
        unique case (w_phase)
            PH_IDLE: n_phase = PH_IDLE;
            PH_BODY: begin
                if (w_idx == 8'd0) begin
                    if (w_too_long) begin
                        n_phase = PH_IDLE;
                    end else if (w_dw == 8'd0) begin
                        n_phase = PH_CRCH;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end else if (w_idx >= r_len) begin
                    n_phase = PH_CRCH;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_CRCH: n_phase = PH_CRCL;
            PH_CRCL: n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_comb begin
        o_push      = w_acc && w_active;
        o_item.dw   = w_dw;
        o_item.idx  = w_idx;
        o_item.len  = r_len;
        o_item.plen = r_len + 8'd1;
        o_item.kind = K_BODY;
        unique case (w_phase)
            PH_BODY: begin
                if (w_idx == 8'd0) begin
                    o_item.kind = w_too_long ? K_LONG : K_LEN;
                    o_item.len  = w_dw;
                    o_item.plen = w_dw + 8'd1;
                end else begin
                    o_item.kind = K_BODY;
                end
            end
            PH_CRCH: o_item.kind = K_CRCH;
            PH_CRCL: o_item.kind = K_CRCL;
            default: o_item.kind = K_BODY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_key     <= PN9_SEED;
            r_carry   <= PN9_CARRY;
            r_count   <= 8'd0;
            r_len     <= 8'd0;
            r_max_len <= MAX_LEN_RESET;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_len <= i_cfg.max_frame_length;
            end
            if (w_acc && w_active) begin
                r_phase <= n_phase;
                r_key   <= n_key;
                r_carry <= n_carry;
                r_count <= w_idx + 8'd1;
                if ((w_phase == PH_BODY) && (w_idx == 8'd0)) begin
                    r_len <= w_dw;
                end
            end
        end
    end

endmodule

// File: hw/rtl/pn9crc_queue.sv
// short fifo between front and back
module pn9crc_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pn9crc_pkg::t_item  i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output pn9crc_pkg::t_item  o_item
);
    import pn9crc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: hw/rtl/pn9crc_back.sv
// back end: crc, payload unscrambling and result register
module pn9crc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  pn9crc_pkg::t_item  i_item,
    output logic               o_pop,
    pn9crc_out_if.source       o_res
);
    import pn9crc_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_prev;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_crch;
    logic        r_out_valid;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_idx;
    logic        r_pay, n_pay;
    logic        r_eof, n_eof;
    logic [1:0]  r_st, n_st;
    logic [7:0]  r_plen, n_plen;
    logic [7:0]  w_chain;

    assign o_pop   = i_valid && (!r_out_valid || o_res.ready);
    assign w_chain = (r_prev + CHAIN_ADD) ^ i_item.dw;

    always_comb begin
        n_crc  = r_crc;
        n_ctrl = r_ctrl;
        n_data = i_item.dw;
        n_pay  = 1'b0;
        n_eof  = 1'b0;
        n_st   = ST_BUSY;
        n_plen = i_item.plen;
        case (i_item.kind)
            K_LEN: begin
                n_crc = crc16_byte(CRC_INIT, i_item.dw);
                n_pay = 1'b1;
            end
            K_BODY: begin
                n_crc = crc16_byte(r_crc, i_item.dw);
                n_pay = 1'b1;
                if (i_item.idx == 8'd1) begin
                    n_data = ~i_item.dw ^ BYTE1_MASK;
                end else if (i_item.idx < i_item.len) begin
                    n_data = w_chain;
                    if (i_item.idx == 8'd2) begin
                        n_ctrl = w_chain;
                    end
                end else if (i_item.idx == 8'd2) begin
                    // two-byte payload end decodes against itself
                    n_ctrl = i_item.dw;
                    n_data = 8'd0;
                end else begin
                    n_data = i_item.dw ^ r_ctrl;
                end
            end
            K_CRCH: begin
            end
            K_CRCL: begin
                n_eof = 1'b1;
                n_st  = ({r_crch, i_item.dw} == r_crc) ? ST_OK : ST_CRC_ERR;
            end
            K_LONG: begin
                n_eof  = 1'b1;
                n_st   = ST_TOO_LONG;
                n_plen = 8'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
            r_idx  <= i_item.idx;
            r_pay  <= n_pay;
            r_eof  <= n_eof;
            r_st   <= n_st;
            r_plen <= n_plen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_crc       <= CRC_INIT;
            r_prev      <= 8'd0;
            r_ctrl      <= 8'd0;
            r_crch      <= 8'd0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_crc       <= n_crc;
                r_ctrl      <= n_ctrl;
                if ((i_item.kind == K_LEN) || (i_item.kind == K_BODY)) begin
                    r_prev <= i_item.dw;
                end
                if (i_item.kind == K_CRCH) begin
                    r_crch <= i_item.dw;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.data_byte      = r_data;
    assign o_res.byte_index     = r_idx;
    assign o_res.is_payload     = r_pay;
    assign o_res.end_of_frame   = r_eof;
    assign o_res.frame_status   = r_st;
    assign o_res.payload_length = r_plen;

endmodule

// File: hw/rtl/pn9_crc16_frame_descrambler_top.sv
// top level of the pn9 dewhitening and crc-16 checking frame receiver
//
// i_byte carries whitened radio bytes with a frame_start mark; i_cfg writes
// max_frame_length (reset 64) and is always ready; o_res carries one result
// per byte that belongs to a frame, bytes outside a frame give none.
// a frame is the length byte, the payload and two crc bytes; the verdict
// (ok, crc error) comes with the last crc byte, and a frame that is too long
// gives a single result on its length byte with status too long.
// one byte per cycle is accepted while the fifo is not full; an accepted byte
// reaches o_res through the fifo and the output register: front end classifies and dewhitens, a
// QUEUE_DEPTH entry fifo decouples it from the back end, whose crc and
// unscrambling results sit in an output register.
// when the receiver stalls the output register holds and the fifo fills;
// i_byte.ready drops only once the fifo is full.
// reset is synchronous and empties the fifo and output register and
// restores the register default.
module pn9_crc16_frame_descrambler_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pn9crc_in_if.sink     i_byte,
    pn9crc_cfg_if.sink    i_cfg,
    pn9crc_out_if.source  o_res
);
    import pn9crc_pkg::*;

    logic  w_push, w_full, w_pop, w_q_valid;
    t_item w_in_item, w_q_item;

    pn9crc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_in_item)
    );

    pn9crc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    pn9crc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

// File: hw/rtl/pn9crc_checker.sv
// port-level assertions for the frame receiver, bound to the top level
module pn9crc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_data_byte,
    input logic [7:0] i_byte_index,
    input logic       i_is_payload,
    input logic       i_end_of_frame,
    input logic [1:0] i_frame_status,
    input logic [7:0] i_payload_length
);
    import pn9crc_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte)
            && $stable(i_frame_status))
    else $error("result changed while stalled");

    a_verdict_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_end_of_frame == (i_frame_status != ST_BUSY)))
    else $error("verdict and end of frame disagree");

    a_payload_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_payload |-> !i_end_of_frame
            && (i_payload_length != 8'd0))
    else $error("payload byte carries end of frame or zero length");

    a_too_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_frame_status == ST_TOO_LONG) |-> !i_is_payload
            && (i_byte_index == 8'd0) && (i_payload_length == 8'd0))
    else $error("malformed too-long report");

endmodule

bind pn9_crc16_frame_descrambler_top pn9crc_checker u_pn9crc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_data_byte      (o_res.data_byte),
    .i_byte_index     (o_res.byte_index),
    .i_is_payload     (o_res.is_payload),
    .i_end_of_frame   (o_res.end_of_frame),
    .i_frame_status   (o_res.frame_status),
    .i_payload_length (o_res.payload_length)
);

// File: tb/tb_pn9_crc16_frame_descrambler_top.sv
// self-checking testbench for the pn9 dewhitening and crc-16 checking frame receiver
`timescale 1ns / 1ps

module tb_pn9_crc16_frame_descrambler_top;
    import pn9crc_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int IDLE_PERCENT   = 37;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_OFF       = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 60;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] idx;
        logic       pay;
        logic       eof;
        logic [1:0] status;
        logic [7:0] plen;
    } t_rx_result;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_CRC_OK
    } t_row_kind;

    typedef struct packed {
        logic [7:0] raw;
        logic       fs;
        t_row_kind  kind;
        logic       has;
        t_rx_result res;
    } t_stim_row;

    localparam t_rx_result NO_RESULT = '0;

    localparam t_stim_row DIRECTED_ROWS [25] = '{
        '{8'h00, 1'b0, ROW_TYPED,   1'b0, NO_RESULT},
        '{8'hC2, 1'b1, ROW_TYPED,   1'b1, '{8'd61, 8'd0, 1'b0, 1'b1, ST_TOO_LONG, 8'd0}},
        '{8'h55, 1'b0, ROW_TYPED,   1'b0, NO_RESULT},
        '{8'hFF, 1'b1, ROW_TYPED,   1'b1, '{8'd0, 8'd0, 1'b1, 1'b0, ST_BUSY, 8'd1}},
        '{8'h00, 1'b0, ROW_CRC_OK,  1'b0, NO_RESULT},
        '{8'h00, 1'b0, ROW_CRC_OK,  1'b0, NO_RESULT},
        '{8'hFF, 1'b1, ROW_TYPED,   1'b1, '{8'd0, 8'd0, 1'b1, 1'b0, ST_BUSY, 8'd1}},
        '{8'h00, 1'b0, ROW_PREDICT, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, ROW_PREDICT, 1'b0, NO_RESULT},
        '{8'hFE, 1'b1, ROW_TYPED,   1'b1, '{8'd1, 8'd0, 1'b1, 1'b0, ST_BUSY, 8'd2}},
        '{8'h00, 1'b0, ROW_PREDICT, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, ROW_CRC_OK,  1'b0, NO_RESULT},
        '{8'h00, 1'b0, ROW_CRC_OK,  1'b0, NO_RESULT},
        '{8'hFD, 1'b1, ROW_TYPED,   1'b1, '{8'd2, 8'd0, 1'b1, 1'b0, ST_BUSY, 8'd3}},
        '{8'hFF, 1'b0, ROW_PREDICT, 1'b0, NO_RESULT},
        '{8'h3C, 1'b0, ROW_PREDICT, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, ROW_PREDICT, 1'b0, NO_RESULT},
        '{8'hAA, 1'b0, ROW_PREDICT, 1'b0, NO_RESULT},
        '{8'hFB, 1'b1, ROW_TYPED,   1'b1, '{8'd4, 8'd0, 1'b1, 1'b0, ST_BUSY, 8'd5}},
        '{8'h00, 1'b0, ROW_PREDICT, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, ROW_PREDICT, 1'b0, NO_RESULT},
        '{8'hA5, 1'b0, ROW_PREDICT, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, ROW_PREDICT, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, ROW_TYPED,   1'b1, '{8'd255, 8'd0, 1'b0, 1'b1, ST_TOO_LONG, 8'd0}},
        '{8'hFF, 1'b0, ROW_TYPED,   1'b0, NO_RESULT}
    };

    logic clk   = 1'b0;
    logic rst_n;

    pn9crc_in_if  byte_if ();
    pn9crc_cfg_if cfg_if ();
    pn9crc_out_if res_if ();

    pn9_crc16_frame_descrambler_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // receiver state as the block should hold it
    t_phase      rx_phase;
    logic [7:0]  key;
    logic        carry;
    logic [15:0] crc;
    logic [7:0]  count;
    logic [7:0]  len_field;
    logic [7:0]  prev_dw;
    logic [7:0]  ctrl_plain;
    logic [7:0]  crc_hi;
    logic [7:0]  max_len;

    t_rx_result expected_results [$];
    int         error_count   = 0;
    int         items_sent    = 0;
    int         stall_request = 0;
    logic       steady        = 1'b0;
    int         stuck_cycles  = 0;

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [15:0] crc16_feed(input logic [15:0] c, input logic [7:0] v);
        logic top;
        for (int b = 0; b < 8; b++) begin
            top = c[15] ^ v[7];
            c   = {c[14:0], 1'b0};
            if (top) begin
                c = c ^ CRC16_GEN;
            end
            v = {v[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic dewhiten_and_check(input logic [7:0] raw, input logic fs,
                                                output t_rx_result r);
        logic [7:0] d;
        logic [7:0] idx;
        logic [7:0] plen;
        logic [7:0] v;
        logic       nc;
        r = NO_RESULT;
        if (fs) begin
            key      = PN9_SEED;
            carry    = PN9_CARRY;
            crc      = CRC_INIT;
            count    = 8'd0;
            rx_phase = PH_BODY;
        end else if (rx_phase == PH_IDLE) begin
            return 1'b0;
        end
        d = raw ^ key;
        for (int b = 0; b < 8; b++) begin
            nc    = key[5] ^ key[0];
            key   = {carry, key[7:1]};
            carry = nc;
        end
        idx  = count;
        plen = len_field + 8'd1;
        case (rx_phase)
            PH_BODY: begin
                if (idx == 8'd0) begin
                    len_field = d;
                    if ({1'b0, d} + LEN_OVERHEAD >= {1'b0, max_len}) begin
                        rx_phase = PH_IDLE;
                        r = '{d, 8'd0, 1'b0, 1'b1, ST_TOO_LONG, 8'd0};
                        return 1'b1;
                    end
                    crc      = crc16_feed(crc, d);
                    prev_dw  = d;
                    count    = 8'd1;
                    rx_phase = (d == 8'd0) ? PH_CRCH : PH_BODY;
                    r = '{d, 8'd0, 1'b1, 1'b0, ST_BUSY, d + 8'd1};
                end else begin
                    if (idx == 8'd1) begin
                        v = ~d ^ BYTE1_MASK;
                    end else if (idx < len_field) begin
                        v = (prev_dw + CHAIN_ADD) ^ d;
                        if (idx == 8'd2) begin
                            ctrl_plain = v;
                        end
                    end else begin
                        // two-byte payload: the control byte is the last byte itself
                        if (idx == 8'd2) begin
                            ctrl_plain = d;
                        end
                        v = d ^ ctrl_plain;
                    end
                    crc     = crc16_feed(crc, d);
                    prev_dw = d;
                    if (idx >= len_field) begin
                        rx_phase = PH_CRCH;
                    end
                    count = idx + 8'd1;
                    r = '{v, idx, 1'b1, 1'b0, ST_BUSY, plen};
                end
            end
            PH_CRCH: begin
                crc_hi   = d;
                rx_phase = PH_CRCL;
                count    = idx + 8'd1;
                r = '{d, idx, 1'b0, 1'b0, ST_BUSY, plen};
            end
            default: begin
                rx_phase = PH_IDLE;
                count    = idx + 8'd1;
                r = '{d, idx, 1'b0, 1'b1, ({crc_hi, d} == crc) ? ST_OK : ST_CRC_ERR, plen};
            end
        endcase
        return 1'b1;
    endfunction

    // whitened crc byte that makes the current frame check out
    function automatic logic [7:0] crc_ok_raw();
        return ((rx_phase == PH_CRCH) ? crc[15:8] : crc[7:0]) ^ key;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < REPORT_LIMIT) begin
            $display("%0t %s: got %0d, expected %0d", $time, what, got, want);
        end
        error_count++;
    endtask

    task automatic push_byte(input logic [7:0] raw, input logic fs, input logic typed = 1'b0,
                             input logic t_has = 1'b0, input t_rx_result t_res = NO_RESULT);
        logic       has;
        t_rx_result r;
        if (!steady) begin
            while ($urandom_range(99, 0) < IDLE_PERCENT) begin
                byte_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        byte_if.valid       <= 1'b1;
        byte_if.raw_byte    <= raw;
        byte_if.frame_start <= fs;
        do @(posedge clk); while (!byte_if.ready);
        has = dewhiten_and_check(raw, fs, r);
        if (typed) begin
            has = t_has;
            r   = t_res;
        end
        items_sent++;
        if (has) begin
            expected_results.push_back(r);
        end
    endtask

    task automatic set_max_length(input logic [7:0] value);
        byte_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_if.valid            <= 1'b1;
        cfg_if.max_frame_length <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        max_len = value;
    endtask

    task automatic run_phase(input int target);
        int         hi_ok;
        int         pick;
        int         cut;
        int         bad_at;
        logic [7:0] len;
        logic [7:0] raw;
        items_sent = 0;
        while (items_sent < target) begin
            if ($urandom_range(99, 0) < 85) begin
                hi_ok = int'(max_len) - 4;
                pick  = $urandom_range(99, 0);
                if (hi_ok < 0 || pick < 10) begin
                    len = 8'($urandom_range(255, (hi_ok < 0) ? 0 : hi_ok + 1));
                end else if (pick < 13) begin
                    len = 8'(hi_ok);
                end else if (pick < 38) begin
                    len = 8'($urandom_range((hi_ok < 30) ? hi_ok : 30, 0));
                end else begin
                    len = 8'($urandom_range((hi_ok < 6) ? hi_ok : 6, 0));
                end
                cut    = ($urandom_range(99, 0) < 10) ? $urandom_range(int'(len) + 2, 1) : -1;
                bad_at = ($urandom_range(99, 0) < 25) ? $urandom_range(1, 0) : -1;
                push_byte(len ^ PN9_SEED, 1'b1);
                if (rx_phase == PH_IDLE) begin
                    repeat ($urandom_range(3, 0)) push_byte(8'($urandom_range(255, 0)), 1'b0);
                end else begin
                    for (int i = 1; i <= int'(len) + 2 && i != cut; i++) begin
                        if (i <= int'(len)) begin
                            raw = 8'($urandom_range(255, 0));
                        end else begin
                            raw = crc_ok_raw();
                            if (i - int'(len) - 1 == bad_at) begin
                                raw = raw ^ 8'(1 << $urandom_range(7, 0));
                            end
                        end
                        push_byte(raw, 1'b0);
                    end
                end
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    push_byte(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0);
                end
            end
        end
    endtask

    initial begin
        rst_n                   <= 1'b0;
        byte_if.valid           <= 1'b0;
        byte_if.raw_byte        <= 8'h00;
        byte_if.frame_start     <= 1'b0;
        cfg_if.valid            <= 1'b0;
        cfg_if.max_frame_length <= 8'h00;
        rx_phase   = PH_IDLE;
        key        = PN9_SEED;
        carry      = PN9_CARRY;
        crc        = CRC_INIT;
        count      = 8'd0;
        len_field  = 8'd0;
        prev_dw    = 8'd0;
        ctrl_plain = 8'd0;
        crc_hi     = 8'd0;
        max_len    = MAX_LEN_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[n]) begin
            case (DIRECTED_ROWS[n].kind)
                ROW_TYPED: begin
                    push_byte(DIRECTED_ROWS[n].raw, DIRECTED_ROWS[n].fs, 1'b1,
                              DIRECTED_ROWS[n].has, DIRECTED_ROWS[n].res);
                end
                ROW_CRC_OK: begin
                    push_byte(crc_ok_raw(), 1'b0);
                end
                default: begin
                    push_byte(DIRECTED_ROWS[n].raw, DIRECTED_ROWS[n].fs);
                end
            endcase
        end
        run_phase(250);

        set_max_length(8'd255);
        stall_request = HOLD_OFF;
        run_phase(400);

        set_max_length(8'd3);
        run_phase(100);

        set_max_length(8'($urandom_range(254, 4)));
        steady = 1'b1;
        run_phase(400);
        steady = 1'b0;

        set_max_length(8'($urandom_range(20, 4)));
        run_phase(300);

        set_max_length(8'd255);
        run_phase(400);

        byte_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("pn9_crc16_frame_descrambler_top: match");
        end else begin
            $display("pn9_crc16_frame_descrambler_top: mismatch");
        end
        $finish;
    end

    // result side back-pressure, with one long hold-off on request
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_request > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall_request) @(posedge clk);
                stall_request = 0;
            end else begin
                res_if.ready <= steady || ($urandom_range(99, 0) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk) begin
        t_rx_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending, data_byte", res_if.data_byte, -1);
            end else begin
                want = expected_results.pop_front();
                if (res_if.data_byte !== want.data) begin
                    report_mismatch("data_byte", res_if.data_byte, want.data);
                end
                if (res_if.byte_index !== want.idx) begin
                    report_mismatch("byte_index", res_if.byte_index, want.idx);
                end
                if (res_if.is_payload !== want.pay) begin
                    report_mismatch("is_payload", res_if.is_payload, want.pay);
                end
                if (res_if.end_of_frame !== want.eof) begin
                    report_mismatch("end_of_frame", res_if.end_of_frame, want.eof);
                end
                if (res_if.frame_status !== want.status) begin
                    report_mismatch("frame_status", res_if.frame_status, want.status);
                end
                if (res_if.payload_length !== want.plen) begin
                    report_mismatch("payload_length", res_if.payload_length, want.plen);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("pn9_crc16_frame_descrambler_top: mismatch");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
